@@ hdl/mcbf_pkg.sv @@
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared types, sizes and helper functions for the multi-channel byte FIFO.
// ----------------------------------------------------------------------------
package mcbf_pkg;

    localparam int CHANNELS = 2;
    localparam int DEPTH    = 256;

    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W   = $clog2(CHANNELS * DEPTH);
    localparam int STORE_DEPTH = CHANNELS * DEPTH;

    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    typedef logic [PTR_W-1:0]    t_ptr;
    typedef logic [CH_IDX_W-1:0] t_ch_idx;
    typedef logic [ADDR_W-1:0]   t_addr;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // Per-item decision handed from the pointer control to the top level.
    typedef struct packed {
        logic        we;
        logic        pop;
        t_addr       addr;
        logic        moved;
        logic [7:0]  fill;
    } t_ctrl;

    function automatic t_ptr fill_of(input t_ptr w, input t_ptr r);
        logic [PTR_W:0] wrap;
        begin
            wrap = DEPTH_X - {1'b0, r} + {1'b0, w};
            fill_of = (w >= r) ? (w - r) : wrap[PTR_W-1:0];
        end
    endfunction

    function automatic t_ptr advance(input t_ptr p);
        advance = (p == PTR_LAST) ? '0 : p + t_ptr'(1);
    endfunction

endpackage

@@ hdl/mcbf_ram.sv @@
// ----------------------------------------------------------------------------
// mcbf_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/mcbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcbf_ctrl
// Per-channel read and write pointers with the push, pop and clear decision.
// ----------------------------------------------------------------------------
module mcbf_ctrl
    import mcbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_command,
    input  logic       i_channel,
    output t_ctrl      o_ctrl
);

    t_ptr r_wp [CHANNELS];
    t_ptr r_rp [CHANNELS];

    t_ch_idx ch;
    logic    ch_ok;
    t_ptr    cur_w, cur_r, n_w, n_r, cur_fill, new_fill;
    t_ctrl   ctrl;

    assign ch    = t_ch_idx'(i_channel);
    assign ch_ok = (32'(i_channel) < CHANNELS);

    always_comb begin
        cur_w    = ch_ok ? r_wp[ch] : '0;
        cur_r    = ch_ok ? r_rp[ch] : '0;
        cur_fill = fill_of(cur_w, cur_r);
        n_w      = cur_w;
        n_r      = cur_r;
        ctrl     = '0;
        case (t_cmd'(i_command))
            CMD_PUSH: begin
                if (ch_ok && cur_fill != PTR_LAST) begin
                    ctrl.we    = 1'b1;
                    ctrl.moved = 1'b1;
                    n_w        = advance(cur_w);
                end
            end
            CMD_POP: begin
                if (ch_ok && cur_fill != '0) begin
                    ctrl.pop   = 1'b1;
                    ctrl.moved = 1'b1;
                    n_r        = advance(cur_r);
                end
            end
            CMD_CLEAR: begin
                n_w = '0;
                n_r = '0;
            end
            default: begin
            end
        endcase
        // The store is split into one contiguous region per channel.
        ctrl.addr = ADDR_W'(32'(ch) * DEPTH + 32'(ctrl.we ? cur_w : cur_r));
        new_fill  = fill_of(n_w, n_r);
        ctrl.fill = ch_ok ? 8'(new_fill) : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_wp[i] <= '0;
                r_rp[i] <= '0;
            end
        end else if (i_accept && ch_ok) begin
            r_wp[ch] <= n_w;
            r_rp[ch] <= n_r;
        end
    end

    assign o_ctrl = '{we:    ctrl.we & i_accept,
                      pop:   ctrl.pop & i_accept,
                      addr:  ctrl.addr,
                      moved: ctrl.moved,
                      fill:  ctrl.fill};

endmodule

@@ hdl/multi_channel_byte_fifo_top.sv @@
// ----------------------------------------------------------------------------
// multi_channel_byte_fifo_top
// Several byte ring buffers sharing one byte store, one command per item.
// ----------------------------------------------------------------------------
// Usage:
//   An item (command, channel, data byte, request-last flag) is taken at a
//   rising edge with start high and busy low. busy stays low, so a new item
//   may be issued in every cycle.
//   Each item produces one result in the following cycle: o_valid is high for one
//   cycle with the popped byte, the moved flag, the channel fill count and
//   the running byte count of the current request. The receiver has no way
//   to stall, so results must be taken when shown.
//   The result is registered, and the popped byte comes from the registered read of the byte store.
//   Pointers live in flip-flops and are updated at acceptance, so an item
//   sees the effect of the item just before it without any stall.
//   Synchronous reset clears all pointers and the request counter; the byte
//   store itself is not cleared, and only entries that were pushed are read.
// ----------------------------------------------------------------------------
module multi_channel_byte_fifo_top
    import mcbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic        i_channel,
    input  logic [7:0]  i_data_in,
    input  logic        i_request_last,
    output logic        o_valid,
    output logic [7:0]  o_data_out,
    output logic        o_moved,
    output logic [7:0]  o_fill_count,
    output logic [15:0] o_request_moved
);

    logic        accept;
    t_ctrl       ctrl;
    logic [7:0]  ram_q;

    logic        r_valid, r_pop, r_moved;
    logic [7:0]  r_fill;
    logic [15:0] r_req_out, r_req_cnt;
    logic [15:0] n_req_out;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    mcbf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (i_command),
        .i_channel (i_channel),
        .o_ctrl    (ctrl)
    );

    mcbf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ctrl.we),
        .i_addr  (ctrl.addr),
        .i_wdata (i_data_in),
        .o_rdata (ram_q)
    );

    assign n_req_out = (ctrl.moved && r_req_cnt != 16'hFFFF) ? r_req_cnt + 16'd1
                                                             : r_req_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pop     <= 1'b0;
            r_req_cnt <= '0;
        end else begin
            r_valid <= accept;
            r_pop   <= ctrl.pop;
            if (accept) begin
                r_req_cnt <= i_request_last ? 16'd0 : n_req_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_moved   <= ctrl.moved;
            r_fill    <= ctrl.fill;
            r_req_out <= n_req_out;
        end
    end

    assign o_valid         = r_valid;
    assign o_data_out      = r_pop ? ram_q : 8'd0;
    assign o_moved         = r_moved;
    assign o_fill_count    = r_fill;
    assign o_request_moved = r_req_out;

endmodule

@@ tb/multi_channel_byte_fifo_top_tb.sv @@
// ----------------------------------------------------------------------------
// multi_channel_byte_fifo_top_tb
// Self-checking bench for the multi-channel byte FIFO. A driver issues push,
// pop, clear and unused-code items from a queue, with random idle bursts. A
// predictor mirrors the ring pointers, the byte store and the request counter
// to compute each expected result, and a monitor checks every result field.
// ----------------------------------------------------------------------------
module multi_channel_byte_fifo_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcbf_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1030;
    localparam int TAIL_ITEMS   = 200;
    localparam int STALL_LIMIT  = 1000;

    typedef struct packed {
        logic [1:0] cmd;
        logic       channel;
        logic [7:0] data;
        logic       last;
    } t_fifo_item;

    typedef struct packed {
        logic [7:0]  data_out;
        logic        moved;
        logic [7:0]  fill;
        logic [15:0] req_moved;
    } t_fifo_result;

    typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_CLEAR} t_seg_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = '0;
    logic        i_channel = 1'b0;
    logic [7:0]  i_data_in = '0;
    logic        i_request_last = 1'b0;
    logic        o_valid;
    logic [7:0]  o_data_out;
    logic        o_moved;
    logic [7:0]  o_fill_count;
    logic [15:0] o_request_moved;

    multi_channel_byte_fifo_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_channel      (i_channel),
        .i_data_in      (i_data_in),
        .i_request_last (i_request_last),
        .o_valid        (o_valid),
        .o_data_out     (o_data_out),
        .o_moved        (o_moved),
        .o_fill_count   (o_fill_count),
        .o_request_moved(o_request_moved)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the block state.
    logic [7:0]  byte_mirror [CHANNELS*DEPTH];
    int          wr_ptr [CHANNELS];
    int          rd_ptr [CHANNELS];
    logic [15:0] request_bytes;

    t_fifo_item   pending_items[$];
    t_fifo_result expected_results[$];
    t_fifo_item   cur_item;
    int           gap_left = 0;
    int           mismatch_count = 0;
    int           result_count = 0;
    int           quiet_cycles = 0;

    function automatic int channel_fill(int ch);
        return (wr_ptr[ch] >= rd_ptr[ch]) ? wr_ptr[ch] - rd_ptr[ch]
                                          : DEPTH - rd_ptr[ch] + wr_ptr[ch];
    endfunction

    function automatic t_fifo_result predict_fifo_result(t_fifo_item it);
        t_fifo_result r;
        int ch;
        r = '0;
        ch = int'(it.channel);
        if (ch < CHANNELS) begin
            case (it.cmd)
                CMD_PUSH: begin
                    if (channel_fill(ch) < DEPTH - 1) begin
                        byte_mirror[ch*DEPTH + wr_ptr[ch]] = it.data;
                        wr_ptr[ch] = (wr_ptr[ch] + 1 >= DEPTH) ? 0 : wr_ptr[ch] + 1;
                        r.moved = 1'b1;
                    end
                end
                CMD_POP: begin
                    if (channel_fill(ch) != 0) begin
                        r.data_out = byte_mirror[ch*DEPTH + rd_ptr[ch]];
                        rd_ptr[ch] = (rd_ptr[ch] + 1 >= DEPTH) ? 0 : rd_ptr[ch] + 1;
                        r.moved = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    wr_ptr[ch] = 0;
                    rd_ptr[ch] = 0;
                end
                default: begin
                end
            endcase
            r.fill = 8'(channel_fill(ch));
        end
        if (r.moved && request_bytes != 16'hFFFF)
            request_bytes = request_bytes + 16'd1;
        r.req_moved = request_bytes;
        if (it.last)
            request_bytes = '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 result_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_item(input logic [1:0] cmd, input logic ch,
                            input logic [7:0] data, input logic last);
        t_fifo_item it;
        it.cmd = cmd;
        it.channel = ch;
        it.data = data;
        it.last = last;
        pending_items.push_back(it);
    endtask

    // Driver: presents one item at a time and holds it while busy is high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(predict_fifo_result(cur_item));
            end
            if (start && busy) begin
                // The presented item waits for acceptance.
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (pending_items.size() == 0) begin
                start <= 1'b0;
            end else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 10);
                start <= 1'b0;
            end else begin
                cur_item = pending_items.pop_front();
                start <= 1'b1;
                i_command <= cur_item.cmd;
                i_channel <= cur_item.channel;
                i_data_in <= cur_item.data;
                i_request_last <= cur_item.last;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_fifo_result want;
        if (i_rst_n && o_valid) begin
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no item pending", 0, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_data_out !== want.data_out)
                    report_mismatch("data_out", o_data_out, want.data_out);
                if (o_moved !== want.moved)
                    report_mismatch("moved", o_moved, want.moved);
                if (o_fill_count !== want.fill)
                    report_mismatch("fill_count", o_fill_count, want.fill);
                if (o_request_moved !== want.req_moved)
                    report_mismatch("request_moved", o_request_moved, want.req_moved);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        t_seg_kind  seg;
        int         seg_len;
        int         made;
        int         pick;
        logic       ch;
        logic [1:0] cmd;

        foreach (byte_mirror[k]) byte_mirror[k] = '0;
        foreach (wr_ptr[k]) begin
            wr_ptr[k] = 0;
            rd_ptr[k] = 0;
        end
        request_bytes = '0;

        // Directed: empty pops, byte extremes, both channels, clears, the
        // unused command code and request ends on several commands.
        add_item(CMD_POP,    1'b0, 8'h5A, 1'b0);
        add_item(CMD_PUSH,   1'b0, 8'h00, 1'b0);
        add_item(CMD_PUSH,   1'b0, 8'hFF, 1'b0);
        add_item(CMD_PUSH,   1'b1, 8'h80, 1'b0);
        add_item(CMD_PUSH,   1'b1, 8'h01, 1'b1);
        add_item(CMD_POP,    1'b0, 8'hFF, 1'b0);
        add_item(CMD_POP,    1'b1, 8'h00, 1'b0);
        add_item(CMD_UNUSED, 1'b0, 8'hFF, 1'b0);
        add_item(CMD_POP,    1'b0, 8'h00, 1'b0);
        add_item(CMD_POP,    1'b0, 8'h00, 1'b0);
        add_item(CMD_CLEAR,  1'b1, 8'hFF, 1'b0);
        add_item(CMD_POP,    1'b1, 8'h00, 1'b0);
        add_item(CMD_PUSH,   1'b1, 8'h7F, 1'b0);
        add_item(CMD_CLEAR,  1'b0, 8'h00, 1'b1);
        add_item(CMD_POP,    1'b1, 8'h00, 1'b1);
        add_item(CMD_PUSH,   1'b0, 8'hAA, 1'b0);
        add_item(CMD_PUSH,   1'b0, 8'h55, 1'b0);
        add_item(CMD_CLEAR,  1'b0, 8'h00, 1'b0);
        add_item(CMD_PUSH,   1'b0, 8'h3C, 1'b0);
        add_item(CMD_POP,    1'b0, 8'hC3, 1'b1);
        add_item(CMD_UNUSED, 1'b1, 8'h00, 1'b1);

        // Random: start by running channel 0 past full, then mix segments
        // that fill, drain, churn or clear a channel.
        for (int k = 0; k < 270; k++)
            add_item(CMD_PUSH, 1'b0, 8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        made = 270;
        while (made < RANDOM_ITEMS) begin
            seg = t_seg_kind'($urandom_range(0, 3));
            ch = 1'($urandom_range(0, 1));
            if (seg == SEG_CLEAR) begin
                seg_len = 1;
            end else if (seg == SEG_MIXED) begin
                seg_len = $urandom_range(1, 60);
            end else begin
                seg_len = $urandom_range(1, 300);
            end
            if (seg_len > RANDOM_ITEMS - made)
                seg_len = RANDOM_ITEMS - made;
            for (int k = 0; k < seg_len; k++) begin
                pick = $urandom_range(0, 99);
                case (seg)
                    SEG_FILL:  cmd = (pick < 90) ? CMD_PUSH : CMD_POP;
                    SEG_DRAIN: cmd = (pick < 90) ? CMD_POP : CMD_PUSH;
                    SEG_CLEAR: cmd = CMD_CLEAR;
                    default: begin
                        if (pick < 46)      cmd = CMD_PUSH;
                        else if (pick < 92) cmd = CMD_POP;
                        else if (pick < 97) cmd = CMD_CLEAR;
                        else                cmd = CMD_UNUSED;
                    end
                endcase
                add_item(cmd, ch, 8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            made += seg_len;
        end

        // Closing stretch without idle cycles.
        for (int k = 0; k < TAIL_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      cmd = CMD_PUSH;
            else if (pick < 90) cmd = CMD_POP;
            else if (pick < 97) cmd = CMD_CLEAR;
            else                cmd = CMD_UNUSED;
            add_item(cmd, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 7) == 0);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/mcbf_pkg.sv
hdl/mcbf_ram.sv
hdl/mcbf_ctrl.sv
hdl/multi_channel_byte_fifo_top.sv
tb/multi_channel_byte_fifo_top_tb.sv
